/* rtl/lerc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lerc_pkg;

    localparam int ENTRIES_DEF = 32;
    localparam int SLOT_W      = 6;
    localparam int LIFE_W      = 2;
    localparam int RASTER_W    = 7;
    localparam int SPRITE_W    = 8;
    localparam int DATA_W      = LIFE_W + RASTER_W + SPRITE_W;
    localparam int SIZE_W      = 6;
    localparam int STRIDE_W    = 16;
    localparam int OFFSET_W    = 21;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [SIZE_W-1:0]    CACHE_SIZE_RST = 6'd18;
    localparam logic [STRIDE_W-1:0]  STRIDE_RST     = 16'd0;
    localparam logic [LIFE_W-1:0]    LIFE_FRESH     = 2'd2;
    localparam logic [LIFE_W-1:0]    LIFE_DEAD      = 2'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RASTER = 1'd1;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef enum logic [1:0] {
        ST_HIT  = 2'd0,
        ST_FILL = 2'd1,
        ST_FULL = 2'd2,
        ST_TICK = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

    typedef struct packed {
        logic               fire;
        t_status            status;
        logic [SLOT_W-1:0]  slot;
    } t_res;

endpackage

`default_nettype wire

/* rtl/lazy_expiry_raster_cache.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Beat
// command   in         start && !busy             i_op, i_raster_id, i_sprite_id
// result    out        o_done, one cycle          o_status, o_slot, o_buffer_offset
// config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// A tick or a missing lookup scans all n entries before o_done, n being
// cache_size capped at ENTRIES; a hit on slot k ends the scan at slot k. With n zero the
// result follows in the next cycle, with no scan.
// The entry RAM has one read port, so the scan covers one entry per cycle.
// busy drops on the cycle o_done rises; a new command may be taken in that cycle.
// Reset marks all entries dead through per-entry valid bits, with no clearing pass.
// The receiver cannot stall; each result beat is shown for exactly one cycle.

module lazy_expiry_raster_cache
    import lerc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_op,
    input  wire logic [RASTER_W-1:0]   i_raster_id,
    input  wire logic [SPRITE_W-1:0]   i_sprite_id,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_done,
    output logic      [1:0]            o_status,
    output logic      [4:0]            o_slot,
    output logic      [OFFSET_W-1:0]   o_buffer_offset
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [SIZE_W-1:0]   r_cache_size;
    logic [STRIDE_W-1:0] r_max_raster;
    logic                r_done;
    t_status             r_status;
    logic [4:0]          r_slot;
    logic [OFFSET_W-1:0] r_offset;

    t_res                w_res;
    logic [SLOT_W+STRIDE_W-1:0] w_prod;

    logic                w_we;
    logic [IW-1:0]       w_waddr;
    logic [DATA_W-1:0]   w_wdata;
    logic                w_re;
    logic [IW-1:0]       w_raddr;
    logic [DATA_W-1:0]   w_rdata;

    lerc_scan #(
        .ENTRIES (ENTRIES)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_op         (i_op),
        .i_raster_id  (i_raster_id),
        .i_sprite_id  (i_sprite_id),
        .i_cache_size (r_cache_size),
        .o_busy       (busy),
        .o_res        (w_res),
        .o_ram_we     (w_we),
        .o_ram_waddr  (w_waddr),
        .o_ram_wdata  (w_wdata),
        .o_ram_re     (w_re),
        .o_ram_raddr  (w_raddr),
        .i_ram_rdata  (w_rdata)
    );

    lerc_ram #(
        .W (DATA_W),
        .D (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_prod = (SLOT_W+STRIDE_W)'(w_res.slot) * (SLOT_W+STRIDE_W)'(r_max_raster);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_size <= CACHE_SIZE_RST;
            r_max_raster <= STRIDE_RST;
            r_done       <= 1'b0;
        end else begin
            r_done <= w_res.fire;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CACHE_SIZE: r_cache_size <= i_cfg_data[SIZE_W-1:0];
                    CFG_MAX_RASTER: r_max_raster <= i_cfg_data[STRIDE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.fire) begin
            r_status <= w_res.status;
            r_slot   <= 5'(w_res.slot);
            r_offset <= w_prod[OFFSET_W-1:0];
        end
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_slot          = r_slot;
    assign o_buffer_offset = r_offset;

endmodule

`default_nettype wire

/* rtl/lerc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module lerc_ram #(
    parameter  int W  = 8,
    parameter  int D  = 32,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/lerc_scan.sv */
`timescale 1ns / 1ps
`default_nettype none

module lerc_scan
    import lerc_pkg::*;
#(
    parameter  int ENTRIES = ENTRIES_DEF,
    localparam int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CW      = $clog2(ENTRIES + 1)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic                i_op,
    input  wire logic [RASTER_W-1:0] i_raster_id,
    input  wire logic [SPRITE_W-1:0] i_sprite_id,
    input  wire logic [SIZE_W-1:0]   i_cache_size,
    output logic                     o_busy,
    output t_res                     o_res,
    output logic                     o_ram_we,
    output logic      [IW-1:0]       o_ram_waddr,
    output logic      [DATA_W-1:0]   o_ram_wdata,
    output logic                     o_ram_re,
    output logic      [IW-1:0]       o_ram_raddr,
    input  wire logic [DATA_W-1:0]   i_ram_rdata
);

    localparam logic [6:0] ENT7 = 7'(ENTRIES);

    t_state              r_state, n_state;
    logic                r_op, n_op;
    logic [RASTER_W-1:0] r_rid, n_rid;
    logic [SPRITE_W-1:0] r_sid, n_sid;
    logic [CW-1:0]       r_n, n_n;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [IW-1:0]       r_pidx, n_pidx;
    logic                r_have_free, n_have_free;
    logic [IW-1:0]       r_free, n_free;
    logic                r_rd_vld;
    logic [ENTRIES-1:0]  r_vld;

    logic [6:0]          w_n7;
    logic [LIFE_W-1:0]   w_life;
    logic                w_live;
    logic                w_match;
    logic                w_last;
    logic [IW-1:0]       w_free_slot;

    assign w_n7    = ({1'b0, i_cache_size} > ENT7) ? ENT7 : {1'b0, i_cache_size};
    assign w_life  = r_rd_vld ? i_ram_rdata[DATA_W-1 -: LIFE_W] : LIFE_DEAD;
    assign w_live  = (w_life != LIFE_DEAD);
    assign w_match = w_live
                   && (i_ram_rdata[SPRITE_W +: RASTER_W] == r_rid)
                   && (i_ram_rdata[SPRITE_W-1:0] == r_sid);
    assign w_last  = (CW'(r_pidx) == (r_n - CW'(1)));
    assign w_free_slot = r_have_free ? r_free : r_pidx;
    assign o_busy  = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend   <= 1'b0;
            r_vld    <= '0;
        end else begin
            r_state  <= n_state;
            r_pend   <= n_pend;
            if (o_ram_we) begin
                r_vld[o_ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_rid       <= n_rid;
        r_sid       <= n_sid;
        r_n         <= n_n;
        r_idx       <= n_idx;
        r_pidx      <= n_pidx;
        r_have_free <= n_have_free;
        r_free      <= n_free;
        if (o_ram_re) begin
            r_rd_vld <= r_vld[o_ram_raddr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_rid       = r_rid;
        n_sid       = r_sid;
        n_n         = r_n;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pidx      = r_pidx;
        n_have_free = r_have_free;
        n_free      = r_free;
        o_res       = '0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_pidx;
        o_ram_wdata = {LIFE_FRESH, r_rid, r_sid};
        o_ram_re    = 1'b0;
        o_ram_raddr = r_idx[IW-1:0];

        case (r_state)
            S_IDLE: begin
                n_pend = 1'b0;
                if (i_start) begin
                    n_op        = i_op;
                    n_rid       = i_raster_id;
                    n_sid       = i_sprite_id;
                    n_n         = CW'(w_n7);
                    n_idx       = '0;
                    n_have_free = 1'b0;
                    if (w_n7 == 7'd0) begin
                        o_res.fire   = 1'b1;
                        o_res.status = (i_op == OP_TICK) ? ST_TICK : ST_FULL;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_idx < r_n) begin
                    o_ram_re = 1'b1;
                    n_idx    = r_idx + CW'(1);
                    n_pend   = 1'b1;
                    n_pidx   = r_idx[IW-1:0];
                end else begin
                    n_pend   = 1'b0;
                end
                if (r_pend) begin
                    if (r_op == OP_TICK) begin
                        if (w_live) begin
                            o_ram_we    = 1'b1;
                            o_ram_wdata = {w_life - LIFE_W'(1),
                                           i_ram_rdata[DATA_W-LIFE_W-1:0]};
                        end
                        if (w_last) begin
                            o_res.fire   = 1'b1;
                            o_res.status = ST_TICK;
                            n_state      = S_IDLE;
                            n_pend       = 1'b0;
                        end
                    end else if (w_match) begin
                        o_ram_we     = 1'b1;
                        o_res.fire   = 1'b1;
                        o_res.status = ST_HIT;
                        o_res.slot   = SLOT_W'(r_pidx);
                        n_state      = S_IDLE;
                        n_pend       = 1'b0;
                    end else begin
                        if (!w_live && !r_have_free) begin
                            n_have_free = 1'b1;
                            n_free      = r_pidx;
                        end
                        if (w_last) begin
                            o_res.fire = 1'b1;
                            n_state    = S_IDLE;
                            n_pend     = 1'b0;
                            if (r_have_free || !w_live) begin
                                o_ram_we     = 1'b1;
                                o_ram_waddr  = w_free_slot;
                                o_res.status = ST_FILL;
                                o_res.slot   = SLOT_W'(w_free_slot);
                            end else begin
                                o_res.status = ST_FULL;
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                n_pend  = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/lerc_chk.sv */
`timescale 1ns / 1ps
`default_nettype none

module lerc_chk
    import lerc_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                o_done,
    input wire logic [1:0]          o_status,
    input wire logic [4:0]          o_slot,
    input wire logic [OFFSET_W-1:0] o_buffer_offset
);

    a_no_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status == ST_TICK || o_status == ST_FULL)
        |-> (o_slot == 5'd0) && (o_buffer_offset == '0))
        else $error("tick or full beat carries a slot or offset");

    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_done)
        else $error("accepted command neither scans nor answers");

    a_finish_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_done)
        else $error("scan ended without a result beat");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while busy");

endmodule

bind lazy_expiry_raster_cache lerc_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_status        (o_status),
    .o_slot          (o_slot),
    .o_buffer_offset (o_buffer_offset)
);

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import lerc_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASES         = 11;

    typedef struct packed {
        t_status               status;
        logic [4:0]            slot;
        logic [OFFSET_W-1:0]   offset;
    } t_cache_reply;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_op;
    logic [RASTER_W-1:0]   i_raster_id;
    logic [SPRITE_W-1:0]   i_sprite_id;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_done;
    logic [1:0]            o_status;
    logic [4:0]            o_slot;
    logic [OFFSET_W-1:0]   o_buffer_offset;

    // predicted cache contents and register copies
    logic [LIFE_W-1:0]     entry_life   [ENTRIES_DEF];
    logic [RASTER_W-1:0]   entry_raster [ENTRIES_DEF];
    logic [SPRITE_W-1:0]   entry_sprite [ENTRIES_DEF];
    logic [SIZE_W-1:0]     cache_sz;
    logic [STRIDE_W-1:0]   slot_stride;

    t_cache_reply          cache_replies [$];
    t_cache_reply          want;
    int                    err_count   = 0;
    int                    stall_cycles = 0;

    lazy_expiry_raster_cache dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_raster_id     (i_raster_id),
        .i_sprite_id     (i_sprite_id),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_slot          (o_slot),
        .o_buffer_offset (o_buffer_offset)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_cache_reply lookup_and_age(input logic op,
                                                    input logic [RASTER_W-1:0] rid,
                                                    input logic [SPRITE_W-1:0] sid);
        t_cache_reply r;
        int n;
        int free_slot;
        r.status = ST_TICK;
        r.slot   = '0;
        r.offset = '0;
        n = (int'(cache_sz) > ENTRIES_DEF) ? ENTRIES_DEF : int'(cache_sz);
        if (op == OP_TICK) begin
            for (int i = 0; i < n; i++) begin
                if (entry_life[i] != LIFE_DEAD) entry_life[i] = entry_life[i] - 1'b1;
            end
            return r;
        end
        free_slot = -1;
        for (int i = 0; i < n; i++) begin
            if (entry_life[i] != LIFE_DEAD) begin
                if (entry_raster[i] == rid && entry_sprite[i] == sid) begin
                    entry_life[i] = LIFE_FRESH;
                    r.status = ST_HIT;
                    r.slot   = 5'(i);
                    r.offset = OFFSET_W'(i * int'(slot_stride));
                    return r;
                end
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (free_slot < 0) begin
            r.status = ST_FULL;
            return r;
        end
        entry_raster[free_slot] = rid;
        entry_sprite[free_slot] = sid;
        entry_life[free_slot]   = LIFE_FRESH;
        r.status = ST_FILL;
        r.slot   = 5'(free_slot);
        r.offset = OFFSET_W'(free_slot * int'(slot_stride));
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, exp_val);
        err_count++;
    endtask

    // send one command beat, return at the edge that accepts it
    task automatic issue_cmd(input logic op, input logic [RASTER_W-1:0] rid,
                             input logic [SPRITE_W-1:0] sid);
        start       <= 1'b1;
        i_op        <= op;
        i_raster_id <= rid;
        i_sprite_id <= sid;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        cache_replies.push_back(lookup_and_age(op, rid, sid));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_CACHE_SIZE) cache_sz = data[SIZE_W-1:0];
        else slot_stride = data;
        @(posedge i_clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (cache_replies.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic test_default_config();
        issue_cmd(OP_LOOKUP, 7'd0, 8'd0);
        issue_cmd(OP_LOOKUP, 7'd127, 8'd255);
        issue_cmd(OP_LOOKUP, 7'd0, 8'd0);
        issue_cmd(OP_LOOKUP, 7'd127, 8'd0);
        issue_cmd(OP_TICK, 7'd0, 8'd0);
        issue_cmd(OP_LOOKUP, 7'd127, 8'd255);
        issue_cmd(OP_TICK, 7'd0, 8'd0);
        issue_cmd(OP_LOOKUP, 7'd0, 8'd0);
        issue_cmd(OP_TICK, 7'd127, 8'd255);
        settle();
    endtask

    task automatic test_single_entry();
        write_reg(CFG_CACHE_SIZE, 16'hFFC1);
        write_reg(CFG_MAX_RASTER, 16'hFFFF);
        issue_cmd(OP_LOOKUP, 7'd1, 8'd2);
        issue_cmd(OP_LOOKUP, 7'd3, 8'd4);
        issue_cmd(OP_LOOKUP, 7'd1, 8'd2);
        issue_cmd(OP_TICK, 7'd0, 8'd0);
        issue_cmd(OP_TICK, 7'd0, 8'd0);
        issue_cmd(OP_LOOKUP, 7'd3, 8'd4);
        settle();
    endtask

    task automatic test_zero_size();
        write_reg(CFG_CACHE_SIZE, 16'd0);
        issue_cmd(OP_LOOKUP, 7'd0, 8'd0);
        issue_cmd(OP_TICK, 7'd0, 8'd0);
        issue_cmd(OP_LOOKUP, 7'd85, 8'd170);
        settle();
    endtask

    task automatic test_oversize();
        write_reg(CFG_CACHE_SIZE, 16'd63);
        write_reg(CFG_MAX_RASTER, 16'd1);
        issue_cmd(OP_LOOKUP, 7'd42, 8'd255);
        issue_cmd(OP_LOOKUP, 7'd42, 8'd128);
        issue_cmd(OP_LOOKUP, 7'd42, 8'd255);
        issue_cmd(OP_TICK, 7'd0, 8'd0);
        issue_cmd(OP_LOOKUP, 7'd42, 8'd128);
        settle();
    endtask

    task automatic run_random_phase(input int items, input int gap_max);
        logic [RASTER_W-1:0] pool_r [48];
        logic [SPRITE_W-1:0] pool_s [48];
        int pool_n;
        int tick_pct;
        int burst;
        int gap;
        int k;
        pool_n   = $urandom_range(1, 48);
        tick_pct = $urandom_range(1, 25);
        burst    = $urandom_range(1, 16);
        for (int j = 0; j < 48; j++) begin
            pool_r[j] = RASTER_W'($urandom);
            pool_s[j] = SPRITE_W'($urandom);
        end
        for (int i = 0; i < items; i++) begin
            k = $urandom_range(0, pool_n - 1);
            if ($urandom_range(0, 99) < tick_pct)
                issue_cmd(OP_TICK, RASTER_W'($urandom), SPRITE_W'($urandom));
            else if ($urandom_range(0, 9) == 0)
                issue_cmd(OP_LOOKUP, RASTER_W'($urandom), SPRITE_W'($urandom));
            else
                issue_cmd(OP_LOOKUP, pool_r[k], pool_s[k]);
            burst--;
            if (burst == 0 && i < items - 1) begin
                burst = $urandom_range(1, 16);
                gap   = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
                if (gap > 0) begin
                    start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        settle();
    endtask

    task automatic test_random_traffic();
        int sizes [PHASES] = '{32, 63, 18, 2, 0, 40, 1, 31, 8, 33, 0};
        int sz;
        logic [STRIDE_W-1:0] stride;
        int gap_max;
        for (int p = 0; p < PHASES; p++) begin
            sz = (p == PHASES - 1) ? $urandom_range(0, 63) : sizes[p];
            case (p % 4)
                0: stride = 16'hFFFF;
                1: stride = 16'h0000;
                2: stride = 16'hFFF0;
                default: stride = STRIDE_W'($urandom);
            endcase
            case (p % 3)
                0: gap_max = 0;
                1: gap_max = 4;
                default: gap_max = 40;
            endcase
            write_reg(CFG_CACHE_SIZE, CFG_DATA_W'(sz));
            write_reg(CFG_MAX_RASTER, stride);
            run_random_phase(105, gap_max);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (cache_replies.size() == 0) begin
                report_mismatch("unexpected beat, status", o_status, -1);
            end else begin
                want = cache_replies.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_slot !== want.slot)
                    report_mismatch("slot", o_slot, want.slot);
                if (o_buffer_offset !== want.offset)
                    report_mismatch("buffer_offset", o_buffer_offset, want.offset);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < ENTRIES_DEF; i++) begin
            entry_life[i]   = LIFE_DEAD;
            entry_raster[i] = '0;
            entry_sprite[i] = 8'hFF;
        end
        cache_sz    = CACHE_SIZE_RST;
        slot_stride = STRIDE_RST;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_op        <= OP_LOOKUP;
        i_raster_id <= '0;
        i_sprite_id <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_CACHE_SIZE;
        i_cfg_data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_config();
        test_single_entry();
        test_zero_size();
        test_oversize();
        test_random_traffic();

        repeat (ENTRIES_DEF + 8) @(posedge i_clk);
        if (err_count == 0 && cache_replies.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
